// ----- rtl/pixel_replicating_image_scaler_unit_assert.svh -----
// Assertion macros shared by the scaler checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PIXEL_REPLICATING_IMAGE_SCALER_UNIT_ASSERT_SVH
`define PIXEL_REPLICATING_IMAGE_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PRIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PRIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pris_pkg.sv -----
// Package for the pixel replicating scaler: widths, reset values, payload and
// control structs, register index codes. No dependencies.
`timescale 1ns / 1ps

package pris_pkg;

  localparam int FRAC_W      = 16;
  localparam int FACTOR_W    = 20;
  localparam int DIM_CFG_W   = 13;
  localparam int BPP_W       = 3;
  localparam int PITCH_W     = 18;
  localparam int DST_W       = 15;
  localparam int ADDR_W      = 32;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int MAX_SCALE_DEF = 8;

  localparam logic [DIM_CFG_W-1:0] RST_DIM    = DIM_CFG_W'(1);
  localparam logic [FACTOR_W-1:0]  RST_FACTOR = FACTOR_W'(1 << FRAC_W);
  localparam logic [BPP_W-1:0]     RST_BPP    = BPP_W'(4);
  localparam logic [PITCH_W-1:0]   RST_PITCH  = PITCH_W'(1);
  localparam logic [7:0]           BYTE_MASK  = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_FACTOR_X   = 3'd2,
    REG_FACTOR_Y   = 3'd3,
    REG_BPP        = 3'd4,
    REG_DST_PITCH  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
  } pix_in_t;

  typedef struct packed {
    logic [DST_W-1:0]  dst_x;
    logic [DST_W-1:0]  dst_y;
    logic [ADDR_W-1:0] byte_address;
    logic [PIX_W-1:0]  pixel_out;
    logic              last_of_run;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer: latch pixel, block origin, step position
    logic emit;    // load output register, step write counters
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_empty;   // a factor rounds up to zero writes
    logic last_write;  // counters sit on the final write of the block
  } dp_sts_t;

endpackage

// ----- rtl/pris_chan_if.sv -----
// Valid/ready channel interface used by all scaler ports.
// Payload type is a parameter; structs come from pris_pkg.
`timescale 1ns / 1ps

interface pris_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pris_ctrl.sv -----
// Controller for the pixel replicating scaler: idle/emit state machine and
// output valid flag. Depends on pris_pkg.
`timescale 1ns / 1ps

module pris_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  pris_pkg::dp_sts_t sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output pris_pkg::dp_cmd_t cmd_o
);
  import pris_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.emit   = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept && !sts_i.run_empty) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd_o.emit && sts_i.last_write) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pris_dpath.sv -----
// Datapath for the pixel replicating scaler: config registers, source
// position, block origin, write counters, address and output register.
// Depends on pris_pkg.
`timescale 1ns / 1ps

module pris_dpath #(
  parameter int MAX_DIM   = pris_pkg::MAX_DIM_DEF,
  parameter int MAX_SCALE = pris_pkg::MAX_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  pris_pkg::cfg_wr_t  cfg_data_i,
  input  pris_pkg::pix_in_t  in_data_i,
  input  pris_pkg::dp_cmd_t  cmd_i,
  output pris_pkg::dp_sts_t  sts_o,
  output pris_pkg::pix_out_t out_data_o
);
  import pris_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DimW  = CW + 1;
  localparam int BxW   = CW + FACTOR_W - FRAC_W;
  localparam int NW    = $clog2(MAX_SCALE + 1);
  localparam int SumW  = (BxW + 1 > DST_W) ? BxW + 1 : DST_W;
  localparam int ProdW = FACTOR_W + CW;
  localparam int RowW  = DST_W + PITCH_W;
  localparam int ColW  = DST_W + BPP_W;
  localparam logic [FACTOR_W-1:0] FxLim = FACTOR_W'(MAX_SCALE * (2 ** FRAC_W));
  localparam logic [DimW-1:0]     DimLim = DimW'(MAX_DIM);

  function automatic logic [DimW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DimLim;
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
    return (f > FxLim) ? FxLim : f;
  endfunction

  function automatic logic [NW-1:0] run_len(input logic [FACTOR_W-1:0] f);
    logic [FACTOR_W:0] s;
    s = {1'b0, f} + (FACTOR_W + 1)'((2 ** FRAC_W) - 1);
    return NW'(s[FACTOR_W:FRAC_W]);
  endfunction

  // Configuration registers
  logic [DIM_CFG_W-1:0] width_q, height_q;
  logic [FACTOR_W-1:0]  fx_q, fy_q;
  logic [BPP_W-1:0]     bpp_q;
  logic [PITCH_W-1:0]   pitch_q;

  // Position and run state
  logic [CW-1:0]  col_q, row_q;
  logic [NW-1:0]  i_q, j_q;
  logic [BxW-1:0] bx_q, by_q;
  logic [PIX_W-1:0] pix_q;
  pix_out_t       out_q;

  logic [DimW-1:0]     w_c, h_c;
  logic [FACTOR_W-1:0] fx_c, fy_c;
  logic [BPP_W-1:0]    bpp_c;
  logic [NW-1:0]       nx, ny;
  logic                i_last, j_last;
  logic [PIX_W-1:0]    pmask;
  logic [ProdW-1:0]    prod_x, prod_y;
  logic [SumW-1:0]     xsum, ysum;
  logic [DST_W-1:0]    x_w, y_w;
  logic [RowW-1:0]     row_off;
  logic [ColW-1:0]     col_off;

  assign w_c   = clamp_dim(width_q);
  assign h_c   = clamp_dim(height_q);
  assign fx_c  = clamp_factor(fx_q);
  assign fy_c  = clamp_factor(fy_q);
  assign bpp_c = (bpp_q == '0) ? BPP_W'(1) : ((bpp_q > BPP_W'(4)) ? BPP_W'(4) : bpp_q);
  assign nx    = run_len(fx_c);
  assign ny    = run_len(fy_c);

  always_comb begin
    for (int k = 0; k < PIX_W / 8; k++) begin
      pmask[8*k +: 8] = (BPP_W'(k) < bpp_c) ? BYTE_MASK : 8'h00;
    end
  end

  // Block origin: floor(factor * position), factor in Q4.16
  assign prod_x = ProdW'(fx_c) * ProdW'(col_q);
  assign prod_y = ProdW'(fy_c) * ProdW'(row_q);

  assign i_last = (i_q == nx - NW'(1));
  assign j_last = (j_q == ny - NW'(1));
  assign sts_o.run_empty  = (nx == '0) || (ny == '0);
  assign sts_o.last_write = i_last && j_last;

  assign xsum    = SumW'(bx_q) + SumW'(i_q);
  assign ysum    = SumW'(by_q) + SumW'(j_q);
  assign x_w     = xsum[DST_W-1:0];
  assign y_w     = ysum[DST_W-1:0];
  assign row_off = RowW'(y_w) * RowW'(pitch_q);
  assign col_off = ColW'(x_w) * ColW'(bpp_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_DIM;
      height_q <= RST_DIM;
      fx_q     <= RST_FACTOR;
      fy_q     <= RST_FACTOR;
      bpp_q    <= RST_BPP;
      pitch_q  <= RST_PITCH;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_data_i.index))
        REG_SRC_WIDTH:  width_q  <= cfg_data_i.wdata[DIM_CFG_W-1:0];
        REG_SRC_HEIGHT: height_q <= cfg_data_i.wdata[DIM_CFG_W-1:0];
        REG_FACTOR_X:   fx_q     <= cfg_data_i.wdata[FACTOR_W-1:0];
        REG_FACTOR_Y:   fy_q     <= cfg_data_i.wdata[FACTOR_W-1:0];
        REG_BPP:        bpp_q    <= cfg_data_i.wdata[BPP_W-1:0];
        REG_DST_PITCH:  pitch_q  <= cfg_data_i.wdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      i_q   <= '0;
      j_q   <= '0;
    end else if (cmd_i.accept) begin
      i_q <= '0;
      j_q <= '0;
      // wrap at the end of a line, and at the end of the image
      if (DimW'(col_q) + DimW'(1) >= w_c) begin
        col_q <= '0;
        if (DimW'(row_q) + DimW'(1) >= h_c) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + CW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end else if (cmd_i.emit) begin
      if (i_last) begin
        i_q <= '0;
        j_q <= j_q + NW'(1);
      end else begin
        i_q <= i_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= in_data_i.pixel_in & pmask;
      bx_q  <= prod_x[ProdW-1:FRAC_W];
      by_q  <= prod_y[ProdW-1:FRAC_W];
    end
    if (cmd_i.emit) begin
      out_q.dst_x        <= x_w;
      out_q.dst_y        <= y_w;
      out_q.byte_address <= row_off[ADDR_W-1:0] + ADDR_W'(col_off);
      out_q.pixel_out    <= pix_q;
      out_q.last_of_run  <= i_last && j_last;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/pixel_replicating_image_scaler_unit.sv -----
// Pixel replicating (nearest neighbor) scaler: one source pixel in, a block of
// ceil(fx) x ceil(fy) destination writes out, one write per cycle while the sink takes them.
// An item is one input transfer plus ceil(fx)*ceil(fy) writes (held longer under output stalls);
// the controller enters its emit state after the transfer, and each write is registered in the output register.
// The single output register and row-offset multiplier set the one-write-per-cycle pace of an unstalled sink.
// Reset: registers to defaults (1x1 source, factors 1.0, 4 bytes, pitch 1), position (0,0).
`timescale 1ns / 1ps

module pixel_replicating_image_scaler_unit #(
  parameter int MAX_DIM   = pris_pkg::MAX_DIM_DEF,
  parameter int MAX_SCALE = pris_pkg::MAX_SCALE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pris_chan_if.sink   in_i,
  pris_chan_if.source out_o,
  pris_chan_if.sink   cfg_i
);
  import pris_pkg::*;

  dp_cmd_t  cmd;
  dp_sts_t  sts;
  pix_out_t out_data;
  logic     in_ready;
  logic     out_valid;

  // Register writes never stall; the user must write them only while the block is idle, the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  // Controller: take a pixel when idle, then walk the write block, one write
  // per free slot in the output register; hold while the sink stalls.
  pris_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  // Datapath: block origin is computed at the input transfer, addresses per write.
  pris_dpath #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data)
  );

  // Ready stays up while the last write of a block still waits to transfer.
  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

// ----- rtl/pris_checker.sv -----
// Port-level checker for the scaler and its bind to the top level.
// Depends on pris_pkg and pixel_replicating_image_scaler_unit_assert.svh.
`timescale 1ns / 1ps
`include "pixel_replicating_image_scaler_unit_assert.svh"

module pris_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input pris_pkg::pix_out_t out_data_i
);

  `PRIS_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i,
                    "output valid dropped while stalled")

  `PRIS_ASSERT_NEXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(out_data_i),
                    "output payload changed while stalled")

  `PRIS_ASSERT_NOW(a_no_take_mid_run, out_valid_i && !out_data_i.last_of_run, !in_ready_i,
                   "input ready while a write block is unfinished")

  `PRIS_ASSERT_NEXT(a_run_continues, out_valid_i && out_ready_i && !out_data_i.last_of_run,
                    out_valid_i, "gap inside a write block")

endmodule

bind pixel_replicating_image_scaler_unit pris_checker u_pris_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
